[sv/metadata_record_stream_parser_assert.svh]
// ============================================================================
// Assertion macros for the metadata record stream parser
// Shared property forms, all clocked on clk and disabled while rst_n is low.
// ============================================================================
`ifndef METADATA_RECORD_STREAM_PARSER_ASSERT_SVH
`define METADATA_RECORD_STREAM_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MRSP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MRSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/mrsp_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// Metadata record stream parser package
// Phase codes, event and error codes, and the result word layout.
// ============================================================================
package mrsp_pkg;

    localparam int BYTE_W       = 8;
    localparam int WORD_W       = 64;
    localparam int STR_LEN_W    = 17;
    localparam int IDX_W        = 3;
    localparam int KIND_W       = 3;
    localparam int TAG_W        = 2;
    localparam int ERR_W        = 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 17;
    localparam int OUT_DATA_W   = 96;
    localparam int OUT_USER_W   = 5;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRY_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_KEY_LENGTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STRING_LENGTH = 2'd2;

    // Register reset values.
    localparam logic [7:0]           RST_MAX_ENTRY_COUNT   = 8'd100;
    localparam logic [7:0]           RST_MAX_KEY_LENGTH    = 8'd255;
    localparam logic [STR_LEN_W-1:0] RST_MAX_STRING_LENGTH = 17'd65536;

    // Event kinds.
    localparam logic [KIND_W-1:0] EV_KEY_BYTE    = 3'd0;
    localparam logic [KIND_W-1:0] EV_STRING_BYTE = 3'd1;
    localparam logic [KIND_W-1:0] EV_ENTRY_DONE  = 3'd2;
    localparam logic [KIND_W-1:0] EV_EMPTY_DONE  = 3'd3;
    localparam logic [KIND_W-1:0] EV_ERROR       = 3'd4;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_BAD_COUNT   = 3'd0;
    localparam logic [ERR_W-1:0] ERR_KEY_LONG    = 3'd1;
    localparam logic [ERR_W-1:0] ERR_BAD_TAG     = 3'd2;
    localparam logic [ERR_W-1:0] ERR_STRING_LONG = 3'd3;
    localparam logic [ERR_W-1:0] ERR_TRUNCATED   = 3'd4;

    // Value tags.
    localparam logic [TAG_W-1:0] TAG_INT64  = 2'd0;
    localparam logic [TAG_W-1:0] TAG_DOUBLE = 2'd1;
    localparam logic [TAG_W-1:0] TAG_STRING = 2'd2;
    localparam logic [TAG_W-1:0] TAG_BOOL   = 2'd3;

    // Byte positions that end the 8-byte and 4-byte fields.
    localparam logic [IDX_W-1:0] LAST_IDX_WORD8 = 3'd7;
    localparam logic [IDX_W-1:0] LAST_IDX_WORD4 = 3'd3;

    typedef enum logic [3:0] {
        PH_COUNT  = 4'd0,
        PH_KEYLEN = 4'd1,
        PH_KEY    = 4'd2,
        PH_TAG    = 4'd3,
        PH_WORD8  = 4'd4,
        PH_STRLEN = 4'd5,
        PH_STR    = 4'd6,
        PH_BOOL   = 4'd7,
        PH_SKIP   = 4'd8
    } phase_t;

    typedef struct packed {
        logic [KIND_W-1:0] event_kind;
        logic [BYTE_W-1:0] byte_out;
        logic [TAG_W-1:0]  value_tag;
        logic [WORD_W-1:0] fixed_value;
        logic [7:0]        key_length;
        logic [7:0]        entry_number;
        logic              last_entry;
        logic [ERR_W-1:0]  error_code;
    } result_t;

endpackage

[sv/mrsp_core.sv]
`timescale 1ns / 1ps
// ============================================================================
// Parser core
// Holds the parse state and works out the next state and the result of one
// accepted byte combinationally.
// ============================================================================
module mrsp_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [mrsp_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          end_marker,
    input  logic [7:0]                    max_entry_count,
    input  logic [7:0]                    max_key_length,
    input  logic [mrsp_pkg::STR_LEN_W-1:0] max_string_length,
    output logic                          res_valid,
    output mrsp_pkg::result_t             res,
    output mrsp_pkg::phase_t              phase
);
    import mrsp_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [WORD_W-1:0]     word_reg, word_next;
    logic [7:0]            entries_reg, entries_next;
    logic [7:0]            entry_idx_reg, entry_idx_next;
    logic [STR_LEN_W-1:0]  remain_reg, remain_next;
    logic [7:0]            key_len_reg, key_len_next;
    logic [TAG_W-1:0]      tag_reg, tag_next;

    logic [WORD_W-1:0]     gathered;
    logic [STR_LEN_W-1:0]  remain_dec;
    logic                  last_entry;

    assign gathered   = word_reg | (WORD_W'(data_byte) << {idx_reg, 3'b000});
    assign remain_dec = remain_reg - STR_LEN_W'(1);
    assign last_entry = (entries_reg <= 8'd1);
    assign phase      = phase_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        word_next      = word_reg;
        entries_next   = entries_reg;
        entry_idx_next = entry_idx_reg;
        remain_next    = remain_reg;
        key_len_next   = key_len_reg;
        tag_next       = tag_reg;
        res_valid      = 1'b0;
        res            = '0;

        if (end_marker)
        begin
            phase_next     = PH_COUNT;
            idx_next       = '0;
            word_next      = '0;
            entries_next   = '0;
            entry_idx_next = '0;
            remain_next    = '0;
            if (!(phase_reg == PH_SKIP || (phase_reg == PH_COUNT && idx_reg == '0)))
            begin
                res_valid      = 1'b1;
                res.event_kind = EV_ERROR;
                res.error_code = ERR_TRUNCATED;
            end
        end
        else
        begin
            case (phase_reg)
                PH_COUNT:
                begin
                    if (idx_reg != LAST_IDX_WORD8)
                    begin
                        word_next = gathered;
                        idx_next  = idx_reg + IDX_W'(1);
                    end
                    else
                    begin
                        idx_next  = '0;
                        word_next = '0;
                        if (gathered > WORD_W'(max_entry_count))
                        begin
                            res_valid      = 1'b1;
                            res.event_kind = EV_ERROR;
                            res.error_code = ERR_BAD_COUNT;
                            phase_next     = PH_SKIP;
                        end
                        else if (gathered == '0)
                        begin
                            res_valid      = 1'b1;
                            res.event_kind = EV_EMPTY_DONE;
                        end
                        else
                        begin
                            entries_next   = gathered[7:0];
                            entry_idx_next = '0;
                            phase_next     = PH_KEYLEN;
                        end
                    end
                end
                PH_KEYLEN:
                begin
                    if (idx_reg != LAST_IDX_WORD4)
                    begin
                        word_next = gathered;
                        idx_next  = idx_reg + IDX_W'(1);
                    end
                    else
                    begin
                        idx_next  = '0;
                        word_next = '0;
                        if (gathered > WORD_W'(max_key_length))
                        begin
                            res_valid      = 1'b1;
                            res.event_kind = EV_ERROR;
                            res.error_code = ERR_KEY_LONG;
                            phase_next     = PH_SKIP;
                        end
                        else
                        begin
                            key_len_next = gathered[7:0];
                            remain_next  = STR_LEN_W'(gathered[7:0]);
                            phase_next   = (gathered[7:0] == 8'd0) ? PH_TAG : PH_KEY;
                        end
                    end
                end
                PH_KEY:
                begin
                    res_valid      = 1'b1;
                    res.event_kind = EV_KEY_BYTE;
                    res.byte_out   = data_byte;
                    remain_next    = remain_dec;
                    if (remain_dec == '0)
                    begin
                        phase_next = PH_TAG;
                    end
                end
                PH_TAG:
                begin
                    idx_next  = '0;
                    word_next = '0;
                    if (data_byte > BYTE_W'(TAG_BOOL))
                    begin
                        res_valid      = 1'b1;
                        res.event_kind = EV_ERROR;
                        res.error_code = ERR_BAD_TAG;
                        phase_next     = PH_SKIP;
                    end
                    else
                    begin
                        tag_next = data_byte[TAG_W-1:0];
                        case (data_byte[TAG_W-1:0])
                            TAG_STRING: phase_next = PH_STRLEN;
                            TAG_BOOL:   phase_next = PH_BOOL;
                            default:    phase_next = PH_WORD8;
                        endcase
                    end
                end
                PH_WORD8, PH_STRLEN, PH_STR, PH_BOOL:
                begin
                    // Entry-done defaults; each value phase fills in what differs.
                    res.event_kind   = EV_ENTRY_DONE;
                    res.value_tag    = tag_reg;
                    res.key_length   = key_len_reg;
                    res.entry_number = entry_idx_reg;
                    res.last_entry   = last_entry;
                    case (phase_reg)
                        PH_WORD8:
                        begin
                            if (idx_reg != LAST_IDX_WORD8)
                            begin
                                word_next = gathered;
                                idx_next  = idx_reg + IDX_W'(1);
                            end
                            else
                            begin
                                res_valid       = 1'b1;
                                res.fixed_value = gathered;
                            end
                        end
                        PH_STRLEN:
                        begin
                            if (idx_reg != LAST_IDX_WORD4)
                            begin
                                word_next = gathered;
                                idx_next  = idx_reg + IDX_W'(1);
                            end
                            else
                            begin
                                // The length stays in the word while the bytes arrive.
                                idx_next  = '0;
                                word_next = gathered;
                                if (gathered > WORD_W'(max_string_length))
                                begin
                                    res             = '0;
                                    res_valid       = 1'b1;
                                    res.event_kind  = EV_ERROR;
                                    res.error_code  = ERR_STRING_LONG;
                                    phase_next      = PH_SKIP;
                                    word_next       = '0;
                                end
                                else if (gathered == '0)
                                begin
                                    res_valid = 1'b1;
                                end
                                else
                                begin
                                    remain_next = gathered[STR_LEN_W-1:0];
                                    phase_next  = PH_STR;
                                end
                            end
                        end
                        PH_STR:
                        begin
                            remain_next = remain_dec;
                            res_valid   = 1'b1;
                            if (remain_dec == '0)
                            begin
                                // The final string byte rides on the entry-done word.
                                res.fixed_value = word_reg;
                                res.byte_out    = data_byte;
                            end
                            else
                            begin
                                res            = '0;
                                res.event_kind = EV_STRING_BYTE;
                                res.byte_out   = data_byte;
                            end
                        end
                        default:
                        begin
                            res_valid       = 1'b1;
                            res.fixed_value = WORD_W'(data_byte != '0);
                        end
                    endcase

                    // Close the entry when an entry-done word goes out.
                    if (res_valid && res.event_kind == EV_ENTRY_DONE)
                    begin
                        idx_next  = '0;
                        word_next = '0;
                        if (last_entry)
                        begin
                            entries_next   = '0;
                            entry_idx_next = '0;
                            phase_next     = PH_COUNT;
                        end
                        else
                        begin
                            entries_next   = entries_reg - 8'd1;
                            entry_idx_next = entry_idx_reg + 8'd1;
                            phase_next     = PH_KEYLEN;
                        end
                    end
                end
                default:
                begin
                    // Skipping: bytes are dropped until the end marker.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_COUNT;
            idx_reg       <= '0;
            word_reg      <= '0;
            entries_reg   <= '0;
            entry_idx_reg <= '0;
            remain_reg    <= '0;
            key_len_reg   <= '0;
            tag_reg       <= '0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            word_reg      <= word_next;
            entries_reg   <= entries_next;
            entry_idx_reg <= entry_idx_next;
            remain_reg    <= remain_next;
            key_len_reg   <= key_len_next;
            tag_reg       <= tag_next;
        end
    end

endmodule

[sv/mrsp_skid.sv]
`timescale 1ns / 1ps
// ============================================================================
// Result output stage
// Output register plus one skid entry, so the input side keeps a registered
// ready and can take a word while a result still waits downstream.
// ============================================================================
module mrsp_skid
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  mrsp_pkg::result_t in_item,
    output logic              in_ready,
    output logic              out_valid,
    output mrsp_pkg::result_t out_item,
    input  logic              out_ready,
    output logic              skid_full
);
    import mrsp_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_item_reg, out_item_next;
    result_t skid_item_reg, skid_item_next;
    logic    take;

    assign take      = out_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign skid_full = skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_item_next   = out_item_reg;
        skid_item_next  = skid_item_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_item_next   = skid_item_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_valid)
        begin
            if (!out_valid_reg || take)
            begin
                out_item_next  = in_item;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_item_next  = in_item;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

endmodule

[sv/metadata_record_stream_parser.sv]
`timescale 1ns / 1ps
// ============================================================================
// Metadata record stream parser
// Parses a serialized metadata record, one byte per input word, into key
// byte, string byte, entry-done, empty-record and error events.
// ============================================================================
// One input word is taken in every clock cycle: each byte only updates a
// small parse state (phase, byte position, assembled field, counters) and is
// checked against the limits combinationally, and its event, if any, lands at
// the same edge in the output register, or in the one-entry skid behind it
// when the output register still holds an event that is not taken at that
// edge. The input side stalls only when both the output register and the
// skid hold events that the consumer has not taken; s_tready comes straight
// from a flip-flop. A record
// is an 8-byte little-endian entry count followed by entries; each entry is
// a 4-byte key length, the key, a tag byte and a value (8 bytes for int64 or
// double, a 4-byte length plus bytes for a string, one byte for a bool).
// Every key byte and every string byte but the last gives its own event; the
// last string byte travels in byte_out of the entry-done event. A zero count
// gives an empty-record event. After any error the parser drops bytes until
// an end marker (s_tlast), which resets it to expect a new count; an end
// marker inside a record reports truncation. Configuration writes are meant
// for idle times only.
// ============================================================================
module metadata_record_stream_parser
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,  // [7:0] data_byte
    input  logic                                s_tlast,  // end_marker
    // Event stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] byte_out, [71:8] fixed_value, [79:72] key_length,
    // [87:80] entry_number, [90:88] error_code, [95:91] zero
    output logic [mrsp_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tlast,  // last_entry
    output logic [mrsp_pkg::OUT_USER_W-1:0]     m_tuser,  // [2:0] event_kind, [4:3] value_tag
    // Configuration writes.
    input  logic                                cfg_we,
    input  logic [mrsp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mrsp_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import mrsp_pkg::*;

`include "metadata_record_stream_parser_assert.svh"

    logic [7:0]           max_entry_count_reg;
    logic [7:0]           max_key_length_reg;
    logic [STR_LEN_W-1:0] max_string_length_reg;

    logic    in_accept;
    logic    core_valid;
    result_t core_res;
    phase_t  core_phase;
    result_t out_item;
    logic    skid_full;

    assign in_accept = s_tvalid && s_tready;

    // Limit registers; an index past the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entry_count_reg   <= RST_MAX_ENTRY_COUNT;
            max_key_length_reg    <= RST_MAX_KEY_LENGTH;
            max_string_length_reg <= RST_MAX_STRING_LENGTH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_ENTRY_COUNT:   max_entry_count_reg   <= cfg_data[7:0];
                CFG_MAX_KEY_LENGTH:    max_key_length_reg    <= cfg_data[7:0];
                CFG_MAX_STRING_LENGTH: max_string_length_reg <= cfg_data[STR_LEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    mrsp_core u_core
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (in_accept),
        .data_byte         (s_tdata),
        .end_marker        (s_tlast),
        .max_entry_count   (max_entry_count_reg),
        .max_key_length    (max_key_length_reg),
        .max_string_length (max_string_length_reg),
        .res_valid         (core_valid),
        .res               (core_res),
        .phase             (core_phase)
    );

    mrsp_skid u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_accept && core_valid),
        .in_item   (core_res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_item  (out_item),
        .out_ready (m_tready),
        .skid_full (skid_full)
    );

    assign m_tdata = {5'b0, out_item.error_code, out_item.entry_number,
                      out_item.key_length, out_item.fixed_value, out_item.byte_out};
    assign m_tlast = out_item.last_entry;
    assign m_tuser = {out_item.value_tag, out_item.event_kind};

    // A held skid entry always sits behind a valid output word.
    `MRSP_ASSERT_SAME(a_skid_behind_out, skid_full, m_tvalid,
        "skid entry held while output register is empty")

    // Only an entry-done event can close a record.
    `MRSP_ASSERT_SAME(a_last_only_on_done, m_tvalid && m_tlast,
        m_tuser[KIND_W-1:0] == EV_ENTRY_DONE,
        "last_entry set on an event that is not entry done")

    // An end marker always leaves the parser waiting for a new count.
    `MRSP_ASSERT_NEXT(a_end_resets_phase, in_accept && s_tlast,
        core_phase == PH_COUNT,
        "parser not back at the count after an end marker")

endmodule
